// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL files of the square finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge of the clock outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: sv/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared constants and control structs of the largest empty square finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CELL_W      = 8;
  localparam int OUT_SIZE_W  = 11;
  localparam int OUT_POS_W   = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_CODE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_GRID_COLS  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_GRID_ROWS  = 11'd1024;
  localparam logic [CELL_W-1:0]     RST_EMPTY_CODE = 8'd46;

  // Cell issued from the scan stage into the update stage.
  typedef struct packed {
    logic accept;
    logic is_free;
    logic grid_end;
  } issue_t;

  // Update stage status seen by the scan stage.
  typedef struct packed {
    logic end_pending;
    logic out_hold;
    logic spare_full;
  } status_t;

endpackage

// File: sv/lesf_row_mem.sv
// ----------------------------------------------------------------------------
// lesf_row_mem
// One-row store of square sizes: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_row_mem #(
  parameter int DEPTH = lesf_pkg::DEF_MAX_COLS,
  parameter int WIDTH = 11,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/lesf_dp_core.sv
// ----------------------------------------------------------------------------
// lesf_dp_core
// Update stage: square size of one cell, row store write back, best square
// tracking and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lesf_dp_core #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int SW = $clog2(MAX_COLS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lesf_pkg::issue_t                  issue,
  input  logic [CW-1:0]                     iss_col,
  input  logic [RW-1:0]                     iss_row,
  input  logic [SW-1:0]                     rd_data,
  output logic                              wr_en,
  output logic [CW-1:0]                     wr_col,
  output logic [SW-1:0]                     wr_size,
  output lesf_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lesf_pkg::OUT_SIZE_W-1:0]   out_square_size,
  output logic [lesf_pkg::OUT_POS_W-1:0]    out_top_row,
  output logic [lesf_pkg::OUT_POS_W-1:0]    out_left_col
);

  localparam int MW = (SW > RW) ? ((SW > CW) ? SW : CW) : ((RW > CW) ? RW : CW);
  localparam int BW = MW + 1;

  logic          s1_valid_r;
  logic          s1_free_r;
  logic          s1_end_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          fwd_r;
  logic [SW-1:0] fwd_data_r;
  logic [SW-1:0] left_r;
  logic [SW-1:0] diag_r;
  logic [SW-1:0] best_size_r;
  logic [RW-1:0] best_top_r;
  logic [CW-1:0] best_left_r;
  logic          out_valid_r;
  logic [SW-1:0] out_size_r;
  logic [RW-1:0] out_top_r;
  logic [CW-1:0] out_left_r;
  logic          spr_valid_r;
  logic [SW-1:0] spr_size_r;
  logic [RW-1:0] spr_top_r;
  logic [CW-1:0] spr_left_r;

  logic [SW-1:0] above;
  logic [SW-1:0] left_v;
  logic [SW-1:0] diag_v;
  logic [SW-1:0] min_lr;
  logic [SW-1:0] min_all;
  logic [SW-1:0] size;
  logic          upd;
  logic [SW-1:0] best_size_nxt;
  logic [RW-1:0] best_top_nxt;
  logic [CW-1:0] best_left_nxt;
  logic          res_push;
  logic [RW-1:0] res_top;
  logic [CW-1:0] res_left;

  always_comb begin
    // A write to the same entry in the cycle of the read is not seen by the
    // read, so the update stage hands its own size forward.
    above   = (s1_row_r == '0) ? '0 : (fwd_r ? fwd_data_r : rd_data);
    left_v  = (s1_col_r == '0) ? '0 : left_r;
    diag_v  = (s1_col_r == '0 || s1_row_r == '0) ? '0 : diag_r;
    min_lr  = (left_v < above) ? left_v : above;
    min_all = (min_lr < diag_v) ? min_lr : diag_v;
    size    = s1_free_r ? (min_all + SW'(1)) : '0;
    upd     = size > best_size_r;
    best_size_nxt = upd ? size : best_size_r;
    best_top_nxt  = upd ? RW'(BW'(s1_row_r) + BW'(1) - BW'(size)) : best_top_r;
    best_left_nxt = upd ? CW'(BW'(s1_col_r) + BW'(1) - BW'(size)) : best_left_r;
    res_push = s1_valid_r && s1_end_r;
    res_top  = (best_size_nxt == '0) ? '0 : best_top_nxt;
    res_left = (best_size_nxt == '0) ? '0 : best_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      best_size_r <= '0;
      best_top_r  <= '0;
      best_left_r <= '0;
      out_valid_r <= 1'b0;
      spr_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue.accept;
      if (s1_valid_r) begin
        if (s1_end_r) begin
          best_size_r <= '0;
          best_top_r  <= '0;
          best_left_r <= '0;
        end else begin
          best_size_r <= best_size_nxt;
          best_top_r  <= best_top_nxt;
          best_left_r <= best_left_nxt;
        end
      end
      // A second result register takes a grid result while the first one is
      // still held, so grid ends can follow each other without a gap.
      if (!out_valid_r || out_ready) begin
        out_valid_r <= spr_valid_r || res_push;
        spr_valid_r <= spr_valid_r && res_push;
      end else if (res_push) begin
        spr_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue.accept) begin
      s1_free_r  <= issue.is_free;
      s1_end_r   <= issue.grid_end;
      s1_col_r   <= iss_col;
      s1_row_r   <= iss_row;
      fwd_r      <= s1_valid_r && (s1_col_r == iss_col);
      fwd_data_r <= size;
    end
    if (s1_valid_r) begin
      left_r <= size;
      diag_r <= above;
    end
    if (!out_valid_r || out_ready) begin
      if (spr_valid_r) begin
        out_size_r <= spr_size_r;
        out_top_r  <= spr_top_r;
        out_left_r <= spr_left_r;
      end else if (res_push) begin
        out_size_r <= best_size_nxt;
        out_top_r  <= res_top;
        out_left_r <= res_left;
      end
    end
    if (res_push && (spr_valid_r || (out_valid_r && !out_ready))) begin
      spr_size_r <= best_size_nxt;
      spr_top_r  <= res_top;
      spr_left_r <= res_left;
    end
  end

  assign wr_en   = s1_valid_r;
  assign wr_col  = s1_col_r;
  assign wr_size = size;

  assign status.end_pending = s1_valid_r && s1_end_r;
  assign status.out_hold    = out_valid_r && !out_ready;
  assign status.spare_full  = spr_valid_r;

  assign out_valid       = out_valid_r;
  assign out_square_size = lesf_pkg::OUT_SIZE_W'(out_size_r);
  assign out_top_row     = lesf_pkg::OUT_POS_W'(out_top_r);
  assign out_left_col    = lesf_pkg::OUT_POS_W'(out_left_r);

  `ASSERT_NEVER(a_result_overrun, clk, rst_n,
    s1_valid_r && s1_end_r && out_valid_r && !out_ready && spr_valid_r,
    "grid result arrived while both result registers were held")
  `ASSERT_PROP(a_result_source, clk, rst_n,
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_end_r),
    "result appeared without a grid end in the update stage")
  `ASSERT_PROP(a_best_monotone, clk, rst_n,
    (s1_valid_r && !s1_end_r) |=> (best_size_r >= $past(best_size_r)),
    "best square shrank within a grid")
  `ASSERT_PROP(a_spare_behind_main, clk, rst_n,
    spr_valid_r |-> out_valid_r,
    "spare result held while the output register was empty")

endmodule

// File: sv/largest_empty_square_finder_top.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder_top
// Streams grid cells in raster order and reports the largest free square.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_cell_byte
//   out      output     out_valid/out_ready  out_square_size, out_top_row, out_left_col
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell per cycle while in_ready is high: a scan stage reads the row store, an update stage
// computes the size and writes it back the next cycle.
// After the last cell of a grid, the update stage register and then the result register hold it.
// After reset a clearing pass zeroes every row store entry; no cell
// is taken during it, configuration writes are.
// Two result registers hold finished grids; after the clearing pass only the last cell of a grid
// waits, and only while its result would find both of them taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module largest_empty_square_finder_top #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lesf_pkg::CELL_W-1:0]         in_cell_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lesf_pkg::OUT_SIZE_W-1:0]     out_square_size,
  output logic [lesf_pkg::OUT_POS_W-1:0]      out_top_row,
  output logic [lesf_pkg::OUT_POS_W-1:0]      out_left_col,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lesf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lesf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = $clog2(MAX_COLS + 1);
  localparam int DIMW = (CW > RW) ? CW : RW;
  localparam int CMPW = ((DIMW > lesf_pkg::CFG_DATA_W) ? DIMW : lesf_pkg::CFG_DATA_W) + 2;

  logic [lesf_pkg::CFG_DATA_W-1:0] grid_cols_r;
  logic [lesf_pkg::CFG_DATA_W-1:0] grid_rows_r;
  logic [lesf_pkg::CELL_W-1:0]     empty_code_r;

  logic          clearing_r;
  logic [CW-1:0] clr_addr_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_nxt;
  logic [RW-1:0] cur_row_nxt;

  logic [CMPW-1:0] cols_ext;
  logic [CMPW-1:0] rows_ext;
  logic [CMPW-1:0] cols_eff;
  logic [CMPW-1:0] rows_eff;
  logic            row_end;
  logic            grid_end;
  logic            res_block;
  logic            accept;

  lesf_pkg::issue_t  issue;
  lesf_pkg::status_t status;

  logic [SW-1:0] rd_data;
  logic          dp_wr_en;
  logic [CW-1:0] dp_wr_col;
  logic [SW-1:0] dp_wr_size;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r  <= lesf_pkg::RST_GRID_COLS;
      grid_rows_r  <= lesf_pkg::RST_GRID_ROWS;
      empty_code_r <= lesf_pkg::RST_EMPTY_CODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        lesf_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_data;
        lesf_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_data;
        lesf_pkg::CFG_EMPTY_CODE: empty_code_r <= cfg_data[lesf_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_ext = CMPW'(grid_cols_r);
    rows_ext = CMPW'(grid_rows_r);
    // Zero counts as one; anything above MAX_COLS or MAX_ROWS counts as that maximum.
    if (cols_ext == '0) begin
      cols_eff = CMPW'(1);
    end else if (cols_ext > CMPW'(MAX_COLS)) begin
      cols_eff = CMPW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_eff = CMPW'(1);
    end else if (rows_ext > CMPW'(MAX_ROWS)) begin
      rows_eff = CMPW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    row_end  = (CMPW'(cur_col_r) + CMPW'(1)) >= cols_eff;
    grid_end = row_end && ((CMPW'(cur_row_r) + CMPW'(1)) >= rows_eff);

    if (row_end) begin
      cur_col_nxt = '0;
      cur_row_nxt = grid_end ? '0 : (cur_row_r + RW'(1));
    end else begin
      cur_col_nxt = cur_col_r + CW'(1);
      cur_row_nxt = cur_row_r;
    end
  end

  // The last cell of a grid waits while two of the held result, the spare
  // result and the result still in the update stage would occupy both slots.
  assign res_block = (status.out_hold && status.spare_full) ||
                     (status.out_hold && status.end_pending) ||
                     (status.spare_full && status.end_pending);
  assign in_ready = !clearing_r && !(grid_end && res_block);
  assign accept   = in_valid && in_ready;

  assign issue.accept   = accept;
  assign issue.is_free  = (in_cell_byte == empty_code_r);
  assign issue.grid_end = grid_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      cur_col_r  <= '0;
      cur_row_r  <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + CW'(1);
        if (clr_addr_r == CW'(MAX_COLS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
    end
  end

  assign mem_we    = clearing_r || dp_wr_en;
  assign mem_waddr = clearing_r ? clr_addr_r : dp_wr_col;
  assign mem_wdata = clearing_r ? '0 : dp_wr_size;

  lesf_row_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (SW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cur_col_r),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  lesf_dp_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue           (issue),
    .iss_col         (cur_col_r),
    .iss_row         (cur_row_r),
    .rd_data         (rd_data),
    .wr_en           (dp_wr_en),
    .wr_col          (dp_wr_col),
    .wr_size         (dp_wr_size),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_square_size (out_square_size),
    .out_top_row     (out_top_row),
    .out_left_col    (out_left_col)
  );

  `ASSERT_NEVER(a_no_cell_in_clear, clk, rst_n, accept && clearing_r,
    "cell transfer during the row store clearing pass")
  `ASSERT_NEVER(a_col_in_range, clk, rst_n, cur_col_r > CW'(MAX_COLS - 1),
    "column counter beyond the row store")
  `ASSERT_NEVER(a_update_write_in_clear, clk, rst_n, dp_wr_en && clearing_r,
    "update stage write collides with the clearing pass")

endmodule
